[hdl/tdh_pkg.sv]
// Shared types and constants for the timer deadline heap.
// Used by the shared arithmetic unit and the top-level sequencer.
package tdh_pkg;

  localparam int TIMEOUT_W = 32;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX  = 32'h7FFF_FFFF;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_NONE = 32'hFFFF_FFFF;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  typedef enum logic [1:0] {
    RK_ACCEPT  = 2'd0,
    RK_REJECT  = 2'd1,
    RK_EXPIRED = 2'd2,
    RK_SUMMARY = 2'd3
  } result_kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic carry;  // add: overflow; sub: a >= b
    logic lt;     // sub: a < b
    logic le;     // sub: a <= b
  } alu_flag_t;

endpackage

[hdl/tdh_mem.sv]
// Heap storage: one write port and two read ports with registered read data.
// Each entry holds a deadline and a handle; no package dependency.
module tdh_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read on that port.
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[hdl/tdh_alu.sv]
// Shared adder/comparator for deadline arithmetic and heap compares.
// Depends on tdh_pkg for the operation code and flag struct.
module tdh_alu import tdh_pkg::*; #(
  parameter int W = 48
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output alu_flag_t      flg
);

  logic         is_sub;
  logic [W-1:0] b_in;
  logic [W:0]   sum;

  assign is_sub = (op == ALU_SUB);
  assign b_in   = is_sub ? ~b : b;
  assign sum    = {1'b0, a} + {1'b0, b_in} + (W+1)'(is_sub);
  assign res    = sum[W-1:0];

  always_comb begin
    flg.carry = sum[W];
    flg.lt    = is_sub && !sum[W];
    flg.le    = is_sub && (!sum[W] || (sum[W-1:0] == '0));
  end

endmodule

[hdl/timer_deadline_heap.sv]
// Timer deadline heap: a one-shot timer queue on a binary min-heap in memory.
// Insert: the deadline is formed as now_ms plus delay, then the new entry climbs the heap,
//   one memory read and one compare per level, until it stops below a parent or at the root.
// Poll: reads the head and compares it with now_ms; a due head is sent and popped, and the
//   last entry sifts down, reading both children and comparing per level. Output stalls hold both.
// One item at a time: the next transfer is taken in the cycle after the last result loads.
// Reset (synchronous, rst_n low) empties the heap and drops any waiting result.
module timer_deadline_heap import tdh_pkg::*; #(
  parameter int DEPTH       = 32,
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata from bit 0: delay, handle_id, now_ms, ready_pending, zero fill
  input  logic [((2*TIME_BITS+HANDLE_BITS+1+7)/8)*8-1:0] in_tdata,
  // tuser: kind
  input  logic [0:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata from bit 0: expired_handle, timeout_ms, zero fill
  output logic [((HANDLE_BITS+TIMEOUT_W+7)/8)*8-1:0] out_tdata,
  // tuser: result_kind
  output logic [1:0] out_tuser,
  output logic out_tlast
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH+1);
  localparam int LW     = AW + 2;
  localparam int MW     = TIME_BITS + HANDLE_BITS;
  localparam int OUT_DW = ((HANDLE_BITS+TIMEOUT_W+7)/8)*8;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_ADD, S_INS_CHK, S_INS_CMP, S_POLL_HEAD, S_POLL_CMP,
    S_POP_MV, S_POP_RD, S_POP_C1, S_POP_C2, S_REPLY
  } st_t;

  st_t                    state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          par_r, par_nxt;
  logic                   hr_r, hr_nxt;
  logic [TIME_BITS-1:0]   mv_dl_r, mv_dl_nxt;
  logic [HANDLE_BITS-1:0] mv_hd_r, mv_hd_nxt;
  logic [TIME_BITS-1:0]   pk_dl_r, pk_dl_nxt;
  logic [HANDLE_BITS-1:0] pk_hd_r, pk_hd_nxt;
  logic [TIME_BITS-1:0]   delay_r, delay_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic                   pending_r, pending_nxt;
  logic                   expired_r, expired_nxt;
  result_kind_t           res_kind_r, res_kind_nxt;
  logic [TIMEOUT_W-1:0]   res_tmo_r, res_tmo_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_kind_t           out_kind_r, out_kind_nxt;
  logic [HANDLE_BITS-1:0] out_hd_r, out_hd_nxt;
  logic [TIMEOUT_W-1:0]   out_tmo_r, out_tmo_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [MW-1:0]          mem_wdata;
  logic                   mem_re_a, mem_re_b;
  logic [AW-1:0]          mem_raddr_a, mem_raddr_b;
  logic [MW-1:0]          rd_a, rd_b;
  logic [TIME_BITS-1:0]   rd_a_dl, rd_b_dl;
  logic [HANDLE_BITS-1:0] rd_a_hd, rd_b_hd;

  alu_op_t                alu_op;
  logic [TIME_BITS-1:0]   alu_a, alu_b, alu_res;
  alu_flag_t              alu_flg;

  logic                   out_free;
  logic [LW-1:0]          left_w, right_w;
  logic [CW-1:0]          cnt_dec;
  logic [63:0]            diff64;
  logic                   take_right;

  assign rd_a_dl = rd_a[MW-1:HANDLE_BITS];
  assign rd_a_hd = rd_a[HANDLE_BITS-1:0];
  assign rd_b_dl = rd_b[MW-1:HANDLE_BITS];
  assign rd_b_hd = rd_b[HANDLE_BITS-1:0];

  tdh_mem #(.DEPTH(DEPTH), .WIDTH(MW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re_a    (mem_re_a),
    .raddr_a (mem_raddr_a),
    .rdata_a (rd_a),
    .re_b    (mem_re_b),
    .raddr_b (mem_raddr_b),
    .rdata_b (rd_b)
  );

  tdh_alu #(.W(TIME_BITS)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .flg (alu_flg)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DW'({out_tmo_r, out_hd_r});

  assign out_free = !out_valid_r || out_tready;
  assign left_w   = LW'({idx_r, 1'b1});
  assign right_w  = left_w + LW'(1);
  assign cnt_dec  = count_r - CW'(1);
  assign diff64   = 64'(alu_res);
  assign take_right = hr_r && alu_flg.lt;

  // Operand select for the shared unit
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = rd_a_dl;
    alu_b  = mv_dl_r;
    unique case (state_r)
      S_INS_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = now_r;
        alu_b  = delay_r;
      end
      S_POLL_CMP: begin
        alu_a = rd_a_dl;
        alu_b = now_r;
      end
      S_POP_C1: begin
        alu_a = rd_b_dl;
        alu_b = rd_a_dl;
      end
      S_POP_C2: begin
        alu_a = mv_dl_r;
        alu_b = pk_dl_r;
      end
      default: begin
        alu_a = rd_a_dl;
        alu_b = mv_dl_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    par_nxt       = par_r;
    hr_nxt        = hr_r;
    mv_dl_nxt     = mv_dl_r;
    mv_hd_nxt     = mv_hd_r;
    pk_dl_nxt     = pk_dl_r;
    pk_hd_nxt     = pk_hd_r;
    delay_nxt     = delay_r;
    now_nxt       = now_r;
    pending_nxt   = pending_r;
    expired_nxt   = expired_r;
    res_kind_nxt  = res_kind_r;
    res_tmo_nxt   = res_tmo_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_hd_nxt    = out_hd_r;
    out_tmo_nxt   = out_tmo_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = {mv_dl_r, mv_hd_r};
    mem_re_a      = 1'b0;
    mem_raddr_a   = '0;
    mem_re_b      = 1'b0;
    mem_raddr_b   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          delay_nxt   = in_tdata[TIME_BITS-1:0];
          mv_hd_nxt   = in_tdata[TIME_BITS+HANDLE_BITS-1:TIME_BITS];
          now_nxt     = in_tdata[2*TIME_BITS+HANDLE_BITS-1:TIME_BITS+HANDLE_BITS];
          pending_nxt = in_tdata[2*TIME_BITS+HANDLE_BITS];
          expired_nxt = 1'b0;
          if (in_tuser[0] == KIND_POLL) begin
            state_nxt = S_POLL_HEAD;
          end else if (count_r == CW'(DEPTH)) begin
            res_kind_nxt = RK_REJECT;
            res_tmo_nxt  = '0;
            state_nxt    = S_REPLY;
          end else begin
            state_nxt = S_INS_ADD;
          end
        end
      end
      S_INS_ADD: begin
        // saturate the deadline at the top of the time range
        mv_dl_nxt = alu_flg.carry ? '1 : alu_res;
        idx_nxt   = count_r[AW-1:0];
        count_nxt = count_r + CW'(1);
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (idx_r == '0) begin
          mem_we       = 1'b1;
          res_kind_nxt = RK_ACCEPT;
          res_tmo_nxt  = '0;
          state_nxt    = S_REPLY;
        end else begin
          par_nxt     = (idx_r - AW'(1)) >> 1;
          mem_re_a    = 1'b1;
          mem_raddr_a = (idx_r - AW'(1)) >> 1;
          state_nxt   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (alu_flg.le) begin
          res_kind_nxt = RK_ACCEPT;
          res_tmo_nxt  = '0;
          state_nxt    = S_REPLY;
        end else begin
          // move the parent down into the hole
          mem_wdata = rd_a;
          idx_nxt   = par_r;
          state_nxt = S_INS_CHK;
        end
      end
      S_POLL_HEAD: begin
        if (count_r == '0) begin
          res_kind_nxt = RK_SUMMARY;
          res_tmo_nxt  = (pending_r || expired_r) ? '0 : TIMEOUT_NONE;
          state_nxt    = S_REPLY;
        end else begin
          mem_re_a    = 1'b1;
          mem_raddr_a = '0;
          state_nxt   = S_POLL_CMP;
        end
      end
      S_POLL_CMP: begin
        if (alu_flg.le) begin
          // head is due: send it, then fetch the last entry to sift down
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RK_EXPIRED;
            out_hd_nxt    = rd_a_hd;
            out_tmo_nxt   = '0;
            out_last_nxt  = 1'b0;
            count_nxt     = cnt_dec;
            expired_nxt   = 1'b1;
            mem_re_a      = 1'b1;
            mem_raddr_a   = cnt_dec[AW-1:0];
            state_nxt     = S_POP_MV;
          end
        end else begin
          res_kind_nxt = RK_SUMMARY;
          if (pending_r || expired_r) begin
            res_tmo_nxt = '0;
          end else if (diff64 > 64'(TIMEOUT_MAX)) begin
            res_tmo_nxt = TIMEOUT_MAX;
          end else begin
            res_tmo_nxt = diff64[TIMEOUT_W-1:0];
          end
          state_nxt = S_REPLY;
        end
      end
      S_POP_MV: begin
        mv_dl_nxt = rd_a_dl;
        mv_hd_nxt = rd_a_hd;
        idx_nxt   = '0;
        state_nxt = (count_r == '0) ? S_POLL_HEAD : S_POP_RD;
      end
      S_POP_RD: begin
        if (left_w >= LW'(count_r)) begin
          mem_we    = 1'b1;
          state_nxt = S_POLL_HEAD;
        end else begin
          mem_re_a    = 1'b1;
          mem_raddr_a = left_w[AW-1:0];
          mem_re_b    = 1'b1;
          mem_raddr_b = right_w[AW-1:0];
          par_nxt     = left_w[AW-1:0];
          hr_nxt      = (right_w < LW'(count_r));
          state_nxt   = S_POP_C1;
        end
      end
      S_POP_C1: begin
        // right child wins only when strictly earlier
        if (take_right) begin
          pk_dl_nxt = rd_b_dl;
          pk_hd_nxt = rd_b_hd;
          par_nxt   = par_r + AW'(1);
        end else begin
          pk_dl_nxt = rd_a_dl;
          pk_hd_nxt = rd_a_hd;
        end
        state_nxt = S_POP_C2;
      end
      S_POP_C2: begin
        mem_we = 1'b1;
        if (alu_flg.le) begin
          state_nxt = S_POLL_HEAD;
        end else begin
          mem_wdata = {pk_dl_r, pk_hd_r};
          idx_nxt   = par_r;
          state_nxt = S_POP_RD;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_hd_nxt    = '0;
          out_tmo_nxt   = res_tmo_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    par_r      <= par_nxt;
    hr_r       <= hr_nxt;
    mv_dl_r    <= mv_dl_nxt;
    mv_hd_r    <= mv_hd_nxt;
    pk_dl_r    <= pk_dl_nxt;
    pk_hd_r    <= pk_hd_nxt;
    delay_r    <= delay_nxt;
    now_r      <= now_nxt;
    pending_r  <= pending_nxt;
    expired_r  <= expired_nxt;
    res_kind_r <= res_kind_nxt;
    res_tmo_r  <= res_tmo_nxt;
    out_kind_r <= out_kind_nxt;
    out_hd_r   <= out_hd_nxt;
    out_tmo_r  <= out_tmo_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
